FILE: rtl/core/gpww_pkg.sv
// ----------------------------------------------------------------------------
// gpww_pkg: shared types and constants for the greedy paragraph word wrap
// Character codes, configuration register indexes, widths and the item and
// configuration structures passed between the wrap modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpww_pkg;

    // Longest usable line, also the depth of the held word store.
    localparam int LINE_MAX = 62;
    localparam int WORD_AW  = $clog2(LINE_MAX);
    localparam int CNT_W    = $clog2(LINE_MAX + 1);
    localparam int COL_W    = 7;
    localparam int W_MIN    = 2;

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_SP  = 8'd32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDENT_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_STOP       = 2'd2;

    localparam logic [11:0] WRAP_LENGTH_RESET    = 12'd72;
    localparam logic [11:0] INDENT_COLUMNS_RESET = 12'd0;
    localparam logic [4:0]  TAB_STOP_RESET       = 5'd8;

    typedef struct packed {
        logic [11:0] wrap_length;
        logic [11:0] indent_columns;
        logic [4:0]  tab_stop;
    } cfg_t;

    // Classified input item: raw byte, byte with newline turned into space.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] ch;
        logic       ws;
        logic       tab;
        logic       pend;
    } item_t;

endpackage

FILE: rtl/core/gpww_ram.sv
// ----------------------------------------------------------------------------
// gpww_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data appears in the cycle after the
// address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/gpww_front.sv
// ----------------------------------------------------------------------------
// gpww_front: input side of the word wrap
// Accepts paragraph bytes, classifies them as whitespace, tab or word
// character, and holds them in a two entry queue for the wrap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpww_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    output logic            item_valid,
    input  logic            item_ready,
    output gpww_pkg::item_t item
);

    gpww_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    gpww_pkg::item_t in_item;
    logic            push;
    logic            pop;

    // A newline counts as a space once wrapping is on; the raw byte is kept
    // for the pass-through case.
    always_comb
    begin
        in_item.raw  = s_tdata;
        in_item.ch   = (s_tdata == gpww_pkg::CH_NL) ? gpww_pkg::CH_SP : s_tdata;
        in_item.tab  = (s_tdata == gpww_pkg::CH_TAB);
        in_item.ws   = (s_tdata == gpww_pkg::CH_TAB) || (s_tdata == gpww_pkg::CH_SP) ||
                       (s_tdata == gpww_pkg::CH_NL);
        in_item.pend = s_tlast;
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("front queue count out of range");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("front queue count missed a push");

    a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("front queue count missed a pop");

endmodule

FILE: rtl/core/gpww_back.sv
// ----------------------------------------------------------------------------
// gpww_back: wrap engine
// Keeps the line state, decides per item which bytes go out, holds the
// current word in a small RAM and drains bytes through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpww_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gpww_pkg::cfg_t  cfg,
    input  logic            item_valid,
    output logic            item_ready,
    input  gpww_pkg::item_t item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    typedef enum logic [3:0] {
        S_SEQ,
        S_MOD,
        S_DECIDE,
        S_HELD,
        S_NL,
        S_WRD_RD,
        S_WRD_EM,
        S_CHR,
        S_FHELD,
        S_FWRD_RD,
        S_FWRD_EM
    } state_t;

    // Bytes still owed for the current item, in output order.
    typedef struct packed {
        logic                       held;
        logic [7:0]                 held_ch;
        logic                       nl;
        logic [gpww_pkg::CNT_W-1:0] wcnt;
        logic                       c;
        logic [7:0]                 c_ch;
        logic                       fheld;
        logic [7:0]                 fheld_ch;
        logic [gpww_pkg::CNT_W-1:0] fwcnt;
    } plan_t;

    state_t                     state_reg,    state_next;
    logic [gpww_pkg::COL_W-1:0] column_reg,   column_next;
    logic                       held_v_reg,   held_v_next;
    logic [7:0]                 held_ch_reg,  held_ch_next;
    logic [gpww_pkg::CNT_W-1:0] wc_reg,       wc_next;
    logic                       bp_reg,       bp_next;
    logic                       wals_reg,     wals_next;
    gpww_pkg::item_t            item_reg,     item_next;
    logic [4:0]                 rem_reg,      rem_next;
    logic [2:0]                 mod_cnt_reg,  mod_cnt_next;
    plan_t                      plan_reg,     plan_next;
    logic [gpww_pkg::CNT_W-1:0] idx_reg,      idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;

    logic                       enabled;
    logic signed [12:0]         wdiff;
    logic [gpww_pkg::CNT_W-1:0] width;
    logic [4:0]                 ts;
    logic [7:0]                 xn;
    logic [5:0]                 mod_tmp;
    logic [2:0]                 mod_bit;
    logic                       can_emit;
    logic                       emit;
    logic [7:0]                 emit_byte;
    logic                       plan_busy;
    logic                       ram_we;
    logic [7:0]                 ram_rdata;

    function automatic logic busy(plan_t p);
        busy = p.held || p.nl || (p.wcnt != '0) || p.c || p.fheld || (p.fwcnt != '0);
    endfunction

    assign enabled = (cfg.wrap_length >= 12'(gpww_pkg::W_MIN));
    assign wdiff   = $signed({1'b0, cfg.wrap_length}) - $signed({1'b0, cfg.indent_columns});

    // Usable width, clamped between two columns and the line store depth.
    always_comb
    begin
        if (wdiff < 13'sd2)
        begin
            width = gpww_pkg::CNT_W'(gpww_pkg::W_MIN);
        end
        else if (wdiff > 13'(gpww_pkg::LINE_MAX))
        begin
            width = gpww_pkg::CNT_W'(gpww_pkg::LINE_MAX);
        end
        else
        begin
            width = wdiff[gpww_pkg::CNT_W-1:0];
        end
    end

    assign ts = (cfg.tab_stop == 5'd0) ? 5'd1 : cfg.tab_stop;

    // rem_reg holds column modulo the tab stop once the divide steps finish.
    assign xn = item_reg.tab ? (8'(column_reg) + 8'(ts) - 8'(rem_reg))
                             : (8'(column_reg) + 8'd1);

    assign mod_bit   = 3'(gpww_pkg::COL_W - 1) - mod_cnt_reg;
    assign mod_tmp   = {rem_reg, column_reg[mod_bit]};
    assign can_emit  = !out_valid_reg || m_tready;
    assign plan_busy = busy(plan_reg);
    assign item_ready = (state_reg == S_SEQ) && !plan_busy;
    assign ram_we    = (state_reg == S_DECIDE) && enabled && !bp_reg && !item_reg.ws &&
                       !wals_reg && held_v_reg && (xn <= 8'(width)) &&
                       (wc_reg < gpww_pkg::CNT_W'(gpww_pkg::LINE_MAX));

    gpww_ram #(
        .WIDTH (8),
        .DEPTH (gpww_pkg::LINE_MAX)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wc_reg[gpww_pkg::WORD_AW-1:0]),
        .wdata (item_reg.ch),
        .raddr (idx_reg[gpww_pkg::WORD_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        column_next   = column_reg;
        held_v_next   = held_v_reg;
        held_ch_next  = held_ch_reg;
        wc_next       = wc_reg;
        bp_next       = bp_reg;
        wals_next     = wals_reg;
        item_next     = item_reg;
        rem_next      = rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        plan_next     = plan_reg;
        idx_next      = idx_reg;
        emit          = 1'b0;
        emit_byte     = 8'd0;

        case (state_reg)
            S_SEQ:
            begin
                idx_next = '0;
                if (plan_reg.held)
                begin
                    state_next = S_HELD;
                end
                else if (plan_reg.nl)
                begin
                    state_next = S_NL;
                end
                else if (plan_reg.wcnt != '0)
                begin
                    state_next = S_WRD_RD;
                end
                else if (plan_reg.c)
                begin
                    state_next = S_CHR;
                end
                else if (plan_reg.fheld)
                begin
                    state_next = S_FHELD;
                end
                else if (plan_reg.fwcnt != '0)
                begin
                    state_next = S_FWRD_RD;
                end
                else if (item_valid)
                begin
                    item_next    = item;
                    rem_next     = 5'd0;
                    mod_cnt_next = 3'd0;
                    state_next   = (item.tab && enabled && !bp_reg) ? S_MOD : S_DECIDE;
                end
            end

            S_MOD:
            begin
                // Restoring remainder, one column bit per cycle, MSB first.
                if (mod_tmp >= 6'(ts))
                begin
                    rem_next = 5'(mod_tmp - 6'(ts));
                end
                else
                begin
                    rem_next = mod_tmp[4:0];
                end
                mod_cnt_next = mod_cnt_reg + 3'd1;
                if (mod_cnt_reg == 3'(gpww_pkg::COL_W - 1))
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                plan_next = '0;
                if (!enabled)
                begin
                    plan_next.held    = held_v_reg;
                    plan_next.held_ch = held_ch_reg;
                    plan_next.wcnt    = wc_reg;
                    plan_next.c       = 1'b1;
                    plan_next.c_ch    = item_reg.raw;
                    column_next  = '0;
                    held_v_next  = 1'b0;
                    held_ch_next = gpww_pkg::CH_SP;
                    wc_next      = '0;
                    bp_next      = 1'b0;
                    wals_next    = 1'b1;
                end
                else
                begin
                    if (bp_reg)
                    begin
                        // An overflow waits for the next word to open a line.
                        if (item_reg.ws)
                        begin
                            plan_next.held    = held_v_reg;
                            plan_next.held_ch = held_ch_reg;
                            held_v_next       = 1'b1;
                            held_ch_next      = item_reg.ch;
                        end
                        else if (held_v_reg)
                        begin
                            plan_next.nl   = 1'b1;
                            plan_next.c    = 1'b1;
                            plan_next.c_ch = item_reg.ch;
                            held_v_next    = 1'b0;
                            column_next    = gpww_pkg::COL_W'(1);
                            bp_next        = 1'b0;
                            wals_next      = 1'b1;
                        end
                        else
                        begin
                            plan_next.c    = 1'b1;
                            plan_next.c_ch = item_reg.ch;
                        end
                    end
                    else if (item_reg.ws)
                    begin
                        plan_next.held    = held_v_reg;
                        plan_next.held_ch = held_ch_reg;
                        plan_next.wcnt    = wc_reg;
                        wc_next           = '0;
                        held_v_next       = 1'b1;
                        held_ch_next      = item_reg.ch;
                        wals_next         = 1'b0;
                        if (xn > 8'(width))
                        begin
                            bp_next = 1'b1;
                        end
                        else
                        begin
                            column_next = xn[gpww_pkg::COL_W-1:0];
                        end
                    end
                    else if (wals_reg || !held_v_reg)
                    begin
                        plan_next.c    = 1'b1;
                        plan_next.c_ch = item_reg.ch;
                        if (xn > 8'(width))
                        begin
                            bp_next = 1'b1;
                        end
                        else
                        begin
                            column_next = xn[gpww_pkg::COL_W-1:0];
                        end
                    end
                    else if (xn > 8'(width))
                    begin
                        // The held whitespace becomes a newline and the word moves down.
                        plan_next.nl   = 1'b1;
                        plan_next.wcnt = wc_reg;
                        plan_next.c    = 1'b1;
                        plan_next.c_ch = item_reg.ch;
                        held_v_next    = 1'b0;
                        column_next    = gpww_pkg::COL_W'(wc_reg) + gpww_pkg::COL_W'(1);
                        wc_next        = '0;
                        wals_next      = 1'b1;
                    end
                    else if (wc_reg < gpww_pkg::CNT_W'(gpww_pkg::LINE_MAX))
                    begin
                        wc_next     = wc_reg + gpww_pkg::CNT_W'(1);
                        column_next = xn[gpww_pkg::COL_W-1:0];
                    end
                    else
                    begin
                        plan_next.c    = 1'b1;
                        plan_next.c_ch = item_reg.ch;
                        column_next    = xn[gpww_pkg::COL_W-1:0];
                    end

                    if (item_reg.pend)
                    begin
                        plan_next.fheld    = held_v_next;
                        plan_next.fheld_ch = held_ch_next;
                        plan_next.fwcnt    = wc_next;
                        column_next  = '0;
                        held_v_next  = 1'b0;
                        held_ch_next = gpww_pkg::CH_SP;
                        wc_next      = '0;
                        bp_next      = 1'b0;
                        wals_next    = 1'b1;
                    end
                end
                state_next = S_SEQ;
            end

            S_HELD:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_byte      = plan_reg.held_ch;
                    plan_next.held = 1'b0;
                    state_next     = S_SEQ;
                end
            end

            S_NL:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    emit_byte    = gpww_pkg::CH_NL;
                    plan_next.nl = 1'b0;
                    state_next   = S_SEQ;
                end
            end

            S_WRD_RD:
            begin
                state_next = S_WRD_EM;
            end

            S_WRD_EM:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_byte      = ram_rdata;
                    plan_next.wcnt = plan_reg.wcnt - gpww_pkg::CNT_W'(1);
                    idx_next       = idx_reg + gpww_pkg::CNT_W'(1);
                    state_next     = (plan_reg.wcnt == gpww_pkg::CNT_W'(1)) ? S_SEQ : S_WRD_RD;
                end
            end

            S_CHR:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_byte   = plan_reg.c_ch;
                    plan_next.c = 1'b0;
                    state_next  = S_SEQ;
                end
            end

            S_FHELD:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_byte       = plan_reg.fheld_ch;
                    plan_next.fheld = 1'b0;
                    state_next      = S_SEQ;
                end
            end

            S_FWRD_RD:
            begin
                state_next = S_FWRD_EM;
            end

            S_FWRD_EM:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_byte       = ram_rdata;
                    plan_next.fwcnt = plan_reg.fwcnt - gpww_pkg::CNT_W'(1);
                    idx_next        = idx_reg + gpww_pkg::CNT_W'(1);
                    state_next      = (plan_reg.fwcnt == gpww_pkg::CNT_W'(1)) ? S_SEQ
                                                                               : S_FWRD_RD;
                end
            end

            default:
            begin
                state_next = S_SEQ;
            end
        endcase
    end

    // The byte that empties the plan is the last one this item causes.
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = !busy(plan_next);
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
            out_byte_next  = out_byte_reg;
            out_last_next  = out_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEQ;
            column_reg    <= '0;
            held_v_reg    <= 1'b0;
            held_ch_reg   <= gpww_pkg::CH_SP;
            wc_reg        <= '0;
            bp_reg        <= 1'b0;
            wals_reg      <= 1'b1;
            plan_reg      <= '0;
            idx_reg       <= '0;
            rem_reg       <= 5'd0;
            mod_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            held_v_reg    <= held_v_next;
            held_ch_reg   <= held_ch_next;
            wc_reg        <= wc_next;
            bp_reg        <= bp_next;
            wals_reg      <= wals_next;
            plan_reg      <= plan_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            mod_cnt_reg   <= mod_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= gpww_pkg::CNT_W'(gpww_pkg::LINE_MAX))
        else $error("held word count beyond store depth");

    a_column: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= gpww_pkg::COL_W'(gpww_pkg::LINE_MAX + 1))
        else $error("column beyond longest line");

    a_plan_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> !plan_busy)
        else $error("new item decided while bytes are still owed");

    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (wc_reg < gpww_pkg::CNT_W'(gpww_pkg::LINE_MAX)))
        else $error("word store written past its depth");

    a_mod_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |=> (state_reg == S_MOD || state_reg == S_DECIDE))
        else $error("tab remainder steps left early");

endmodule

FILE: rtl/core/greedy_paragraph_word_wrap.sv
// ----------------------------------------------------------------------------
// greedy_paragraph_word_wrap: greedy re-breaking of a byte stream paragraph
// Bytes arrive one item at a time and leave in the same order, with the
// whitespace before a word that would overflow the line turned into a
// newline. The input side queues up to two items, so it keeps accepting
// while the wrap engine works. The engine handles one item at a time: a word
// character that is only held goes through the sequence and decide states, a
// byte passed straight out also goes through the character state, a tab
// first, when wrapping is on, steps through the column remainder by the tab
// stop (one bit per cycle), and each byte of a held word drained from the word
// store takes a read and an emit state because that RAM has a registered read
// port. The last byte an item causes carries tlast. Configuration writes
// are taken in any cycle; they are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_paragraph_word_wrap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // paragraph_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    gpww_pkg::cfg_t  cfg_reg;
    gpww_pkg::cfg_t  cfg_next;
    logic            item_valid;
    logic            item_ready;
    gpww_pkg::item_t item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                gpww_pkg::CFG_WRAP_LENGTH:    cfg_next.wrap_length    = cfg_data;
                gpww_pkg::CFG_INDENT_COLUMNS: cfg_next.indent_columns = cfg_data;
                gpww_pkg::CFG_TAB_STOP:       cfg_next.tab_stop       = cfg_data[4:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_length    <= gpww_pkg::WRAP_LENGTH_RESET;
            cfg_reg.indent_columns <= gpww_pkg::INDENT_COLUMNS_RESET;
            cfg_reg.tab_stop       <= gpww_pkg::TAB_STOP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gpww_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    gpww_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast)
    );

endmodule
